// ===== rtl/ppwd_pkg.sv =====
// ----------------------------------------------------------------------------
// ppwd_pkg
// Shared types and constants for the placement pair weighted distance core.
// ----------------------------------------------------------------------------
package ppwd_pkg;

  localparam int NODE_W     = 6;
  localparam int NODE_EXT_W = 11;   // holds any node count up to 1024
  localparam int LEN_W      = 24;
  localparam int WEIGHT_W   = 17;
  localparam int SUM_W      = 40;
  localparam int DMIN_W     = 26;   // three Q8.16 lengths added
  localparam int DPEND_W    = 27;   // plus two pendant lengths
  localparam int WPROD_W    = 33;   // product of two clamped weights
  localparam int TERM_W     = 28;
  localparam int KIND_W     = 2;

  localparam logic [WEIGHT_W-1:0] WEIGHT_ONE = 17'h10000;

  // request field layout on the slave tdata bus
  localparam int IN_TDATA_W  = 112;
  localparam int F_FIRST_LSB  = 0;
  localparam int F_SECOND_LSB = 6;
  localparam int F_EDGE_LSB   = 12;
  localparam int F_LEN_LSB    = 18;
  localparam int F_BRANCH_LSB = 42;
  localparam int F_PEND_LSB   = 66;
  localparam int F_WEIGHT_LSB = 90;

  localparam int OUT_TDATA_W = 40;

  typedef enum logic [KIND_W-1:0] {
    KIND_TABLE = 2'd0,
    KIND_A     = 2'd1,
    KIND_B     = 2'd2,
    KIND_NONE  = 2'd3
  } kind_t;

  typedef enum logic [1:0] {
    SEL_PP = 2'd0,
    SEL_PD = 2'd1,
    SEL_DP = 2'd2
  } tbl_sel_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_AREAD,
    ST_RD_PP,
    ST_RD_PD,
    ST_RD_DP,
    ST_MIN,
    ST_PEND,
    ST_MUL,
    ST_TERM,
    ST_ACC,
    ST_EMIT
  } state_t;

  // stored placement; distal length is kept instead of branch length
  typedef struct packed {
    logic [NODE_W-1:0]   prim;
    logic [NODE_W-1:0]   sec;
    logic [NODE_W-1:0]   edge_id;
    logic [LEN_W-1:0]    prox;
    logic [LEN_W-1:0]    distal;
    logic [LEN_W-1:0]    pend;
    logic [WEIGHT_W-1:0] weight;
  } place_t;

  typedef struct packed {
    logic     tbl_wr;
    logic     a_store;
    logic     b_load;
    logic     idx_clr;
    logic     idx_inc;
    logic     a_rd;
    logic     tbl_rd;
    tbl_sel_t tbl_sel;
    logic     cap_pp;
    logic     cap_pd;
    logic     calc_min;
    logic     calc_pend;
    logic     calc_mul;
    logic     calc_term;
    logic     acc;
    logic     emit;
  } cmd_t;

  typedef struct packed {
    logic a_empty;
    logic last_pair;
    logic out_busy;
  } stat_t;

endpackage

// ===== rtl/placement_pair_weighted_distance_core.sv =====
// ----------------------------------------------------------------------------
// placement_pair_weighted_distance_core
// Weighted pairwise distance between two placement sets on a tree.
// ----------------------------------------------------------------------------
// Usage:
//   Slave channel (s_*) carries one request per handshake; s_tuser is the kind.
//   Kind table writes one node-to-node distance, kind A stores a set A
//   placement, kind B compares a placement with every stored A placement.
//   A kind B request runs each pair with a stored A placement through the
//   sequencer once -- A store read, three reads of the single-read-port
//   distance table, min, pendant/weight, two-part multiply, term,
//   saturating accumulate.
//   After a kind B request with s_tlast high the sum leaves on the master
//   channel: m_tdata = Q24.16 sum, m_tuser = overflow flag. An emit step
//   loads the result into the output register and raises m_tvalid.
//   The result sits in an output register; new requests are taken while it
//   waits. Only a further result stalls, in its emit step, until the receiver
//   takes the previous one.
//   Reset clears counts, the sum and the flags; the distance table and the
//   A store hold nothing defined until written. There is no clearing pass.
//   cfg_we/cfg_wdata write add_pendant; write it only while the core is idle.
// ----------------------------------------------------------------------------
module placement_pair_weighted_distance_core #(
  parameter int MAX_NODES      = 64,
  parameter int MAX_PLACEMENTS = 16
) (
  input  logic                              clk,
  input  logic                              rst,
  // fields low to high: first_node, second_node, edge_id, length_value,
  // edge_len, pend_len, weight_ratio, zero fill
  input  logic                              s_tvalid,
  output logic                              s_tready,
  input  logic [ppwd_pkg::IN_TDATA_W-1:0]   s_tdata,
  input  logic [1:0]                        s_tuser,   // kind
  input  logic                              s_tlast,   // last set B placement
  // fields: distance_sum
  output logic                              m_tvalid,
  input  logic                              m_tready,
  output logic [ppwd_pkg::OUT_TDATA_W-1:0]  m_tdata,
  output logic [0:0]                        m_tuser,   // overflow_flag
  input  logic                              cfg_we,
  input  logic                              cfg_wdata  // add_pendant
);

  ppwd_pkg::cmd_t  cmd;
  ppwd_pkg::stat_t stat;

  // sequencer: request decode and per-pair step order
  ppwd_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tuser  (s_tuser),
    .s_tlast  (s_tlast),
    .stat     (stat),
    .cmd      (cmd)
  );

  // storage, arithmetic, accumulator, result register
  ppwd_dpath #(
    .MAX_NODES      (MAX_NODES),
    .MAX_PLACEMENTS (MAX_PLACEMENTS)
  ) u_dpath (
    .clk       (clk),
    .rst       (rst),
    .s_tdata   (s_tdata),
    .cmd       (cmd),
    .stat      (stat),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .m_tuser   (m_tuser)
  );

  // a new result never overwrites one the receiver has not taken
  a_emit_free: assert property (@(posedge clk) disable iff (rst)
    cmd.emit |-> !stat.out_busy)
    else $error("result loaded while previous result stalled");

  // pair loop only runs with a non-empty A set
  a_read_nonempty: assert property (@(posedge clk) disable iff (rst)
    cmd.a_rd |-> !stat.a_empty)
    else $error("A store read with empty set");

  // kind B with empty set and no last finishes at once
  a_empty_b_quick: assert property (@(posedge clk) disable iff (rst)
    (s_tvalid && s_tready && (s_tuser == ppwd_pkg::KIND_B) && stat.a_empty && !s_tlast)
    |=> s_tready)
    else $error("empty-set B request did not complete in one cycle");

endmodule

// ===== rtl/ppwd_ctrl.sv =====
// ----------------------------------------------------------------------------
// ppwd_ctrl
// Sequencer: decodes requests and steps the datapath through each A/B pair.
// ----------------------------------------------------------------------------
module ppwd_ctrl (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  s_tvalid,
  output logic                  s_tready,
  input  logic [1:0]            s_tuser,
  input  logic                  s_tlast,
  input  ppwd_pkg::stat_t       stat,
  output ppwd_pkg::cmd_t        cmd
);

  ppwd_pkg::state_t state, state_next;
  logic             b_last;
  logic             accept;

  assign s_tready = (state == ppwd_pkg::ST_IDLE);
  assign accept   = s_tvalid && s_tready;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ppwd_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    if (accept && (ppwd_pkg::kind_t'(s_tuser) == ppwd_pkg::KIND_B)) begin
      b_last <= s_tlast;
    end
  end

  always_comb begin
    state_next  = state;
    cmd         = '0;
    cmd.tbl_sel = ppwd_pkg::SEL_PP;
    unique case (state)
      ppwd_pkg::ST_IDLE: begin
        if (accept) begin
          unique case (ppwd_pkg::kind_t'(s_tuser))
            ppwd_pkg::KIND_TABLE: cmd.tbl_wr = 1'b1;
            ppwd_pkg::KIND_A:     cmd.a_store = 1'b1;
            ppwd_pkg::KIND_B: begin
              cmd.b_load  = 1'b1;
              cmd.idx_clr = 1'b1;
              if (!stat.a_empty) begin
                state_next = ppwd_pkg::ST_AREAD;
              end else if (s_tlast) begin
                state_next = ppwd_pkg::ST_EMIT;
              end
            end
            default: ;
          endcase
        end
      end
      ppwd_pkg::ST_AREAD: begin
        cmd.a_rd   = 1'b1;
        state_next = ppwd_pkg::ST_RD_PP;
      end
      ppwd_pkg::ST_RD_PP: begin
        cmd.tbl_rd  = 1'b1;
        cmd.tbl_sel = ppwd_pkg::SEL_PP;
        state_next  = ppwd_pkg::ST_RD_PD;
      end
      ppwd_pkg::ST_RD_PD: begin
        cmd.cap_pp  = 1'b1;
        cmd.tbl_rd  = 1'b1;
        cmd.tbl_sel = ppwd_pkg::SEL_PD;
        state_next  = ppwd_pkg::ST_RD_DP;
      end
      ppwd_pkg::ST_RD_DP: begin
        cmd.cap_pd  = 1'b1;
        cmd.tbl_rd  = 1'b1;
        cmd.tbl_sel = ppwd_pkg::SEL_DP;
        state_next  = ppwd_pkg::ST_MIN;
      end
      ppwd_pkg::ST_MIN: begin
        cmd.calc_min = 1'b1;
        state_next   = ppwd_pkg::ST_PEND;
      end
      ppwd_pkg::ST_PEND: begin
        cmd.calc_pend = 1'b1;
        state_next    = ppwd_pkg::ST_MUL;
      end
      ppwd_pkg::ST_MUL: begin
        cmd.calc_mul = 1'b1;
        state_next   = ppwd_pkg::ST_TERM;
      end
      ppwd_pkg::ST_TERM: begin
        cmd.calc_term = 1'b1;
        state_next    = ppwd_pkg::ST_ACC;
      end
      ppwd_pkg::ST_ACC: begin
        cmd.acc = 1'b1;
        if (stat.last_pair) begin
          state_next = b_last ? ppwd_pkg::ST_EMIT : ppwd_pkg::ST_IDLE;
        end else begin
          cmd.idx_inc = 1'b1;
          state_next  = ppwd_pkg::ST_AREAD;
        end
      end
      ppwd_pkg::ST_EMIT: begin
        if (!stat.out_busy) begin
          cmd.emit   = 1'b1;
          state_next = ppwd_pkg::ST_IDLE;
        end
      end
      default: state_next = ppwd_pkg::ST_IDLE;
    endcase
  end

endmodule

// ===== rtl/ppwd_dpath.sv =====
// ----------------------------------------------------------------------------
// ppwd_dpath
// Distance table, set A store, pair distance arithmetic and result register.
// ----------------------------------------------------------------------------
module ppwd_dpath #(
  parameter int MAX_NODES      = 64,
  parameter int MAX_PLACEMENTS = 16
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic [ppwd_pkg::IN_TDATA_W-1:0]     s_tdata,
  input  ppwd_pkg::cmd_t                      cmd,
  output ppwd_pkg::stat_t                     stat,
  input  logic                                cfg_we,
  input  logic                                cfg_wdata,
  output logic                                m_tvalid,
  input  logic                                m_tready,
  output logic [ppwd_pkg::OUT_TDATA_W-1:0]    m_tdata,
  output logic [0:0]                          m_tuser
);

  localparam int TBL_DEPTH = MAX_NODES * MAX_NODES;
  localparam int TAW       = $clog2(TBL_DEPTH);
  localparam int CW        = $clog2(MAX_PLACEMENTS + 1);
  localparam int IW        = (MAX_PLACEMENTS > 1) ? $clog2(MAX_PLACEMENTS) : 1;
  localparam int FULL_W    = 2 * ppwd_pkg::NODE_EXT_W;
  localparam int PROD_W    = ppwd_pkg::DPEND_W + ppwd_pkg::WPROD_W;

  // ---- request fields
  logic [ppwd_pkg::NODE_W-1:0]   f_first, f_second, f_edge;
  logic [ppwd_pkg::LEN_W-1:0]    f_len, f_branch, f_pend;
  logic [ppwd_pkg::WEIGHT_W-1:0] f_weight;
  ppwd_pkg::place_t              in_place;

  assign f_first  = s_tdata[ppwd_pkg::F_FIRST_LSB  +: ppwd_pkg::NODE_W];
  assign f_second = s_tdata[ppwd_pkg::F_SECOND_LSB +: ppwd_pkg::NODE_W];
  assign f_edge   = s_tdata[ppwd_pkg::F_EDGE_LSB   +: ppwd_pkg::NODE_W];
  assign f_len    = s_tdata[ppwd_pkg::F_LEN_LSB    +: ppwd_pkg::LEN_W];
  assign f_branch = s_tdata[ppwd_pkg::F_BRANCH_LSB +: ppwd_pkg::LEN_W];
  assign f_pend   = s_tdata[ppwd_pkg::F_PEND_LSB   +: ppwd_pkg::LEN_W];
  assign f_weight = s_tdata[ppwd_pkg::F_WEIGHT_LSB +: ppwd_pkg::WEIGHT_W];

  always_comb begin
    in_place.prim    = f_first;
    in_place.sec     = f_second;
    in_place.edge_id = f_edge;
    in_place.prox    = f_len;
    in_place.distal  = (f_branch > f_len) ? (f_branch - f_len) : '0;
    in_place.pend    = f_pend;
    in_place.weight  = (f_weight > ppwd_pkg::WEIGHT_ONE) ? ppwd_pkg::WEIGHT_ONE : f_weight;
  end

  function automatic logic node_ok(input logic [ppwd_pkg::NODE_W-1:0] n);
    return ppwd_pkg::NODE_EXT_W'(n) < ppwd_pkg::NODE_EXT_W'(MAX_NODES);
  endfunction

  function automatic logic [TAW-1:0] tbl_addr(input logic [ppwd_pkg::NODE_W-1:0] r,
                                              input logic [ppwd_pkg::NODE_W-1:0] c);
    logic [FULL_W-1:0] full;
    full = FULL_W'(r) * FULL_W'(MAX_NODES) + FULL_W'(c);
    return full[TAW-1:0];
  endfunction

  // ---- node distance table
  logic [ppwd_pkg::LEN_W-1:0] tbl_mem [TBL_DEPTH];
  logic [ppwd_pkg::LEN_W-1:0] tbl_q;
  logic                       tbl_ok;
  logic [ppwd_pkg::NODE_W-1:0] rd_row, rd_col;

  always_ff @(posedge clk) begin
    if (cmd.tbl_wr && node_ok(f_first) && node_ok(f_second)) begin
      tbl_mem[tbl_addr(f_first, f_second)] <= f_len;
    end
  end

  ppwd_pkg::place_t a_q, b_reg;

  always_comb begin
    case (cmd.tbl_sel)
      ppwd_pkg::SEL_PD: begin
        rd_row = a_q.prim;
        rd_col = b_reg.sec;
      end
      ppwd_pkg::SEL_DP: begin
        rd_row = a_q.sec;
        rd_col = b_reg.prim;
      end
      default: begin
        rd_row = a_q.prim;
        rd_col = b_reg.prim;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (cmd.tbl_rd) begin
      tbl_q  <= tbl_mem[tbl_addr(rd_row, rd_col)];
      tbl_ok <= node_ok(rd_row) && node_ok(rd_col);
    end
  end

  // ---- set A store
  ppwd_pkg::place_t a_mem [MAX_PLACEMENTS];
  logic [CW-1:0]    a_count, eff_count;
  logic [IW-1:0]    idx;
  logic             new_set_pending;
  logic             room;

  assign eff_count = new_set_pending ? '0 : a_count;
  assign room      = eff_count < CW'(MAX_PLACEMENTS);

  always_ff @(posedge clk) begin
    if (cmd.a_store && room) begin
      a_mem[eff_count[IW-1:0]] <= in_place;
    end
    if (cmd.a_rd) begin
      a_q <= a_mem[idx];
    end
  end

  // ---- pair arithmetic
  logic [ppwd_pkg::LEN_W-1:0]    t_pp, t_pd, t_dp;
  logic [ppwd_pkg::DMIN_W-1:0]   s_pp, s_pd, s_dp, s_min, d_min;
  logic [ppwd_pkg::DPEND_W-1:0]  d_pend;
  logic [2*ppwd_pkg::WEIGHT_W-1:0] w_full;
  logic [ppwd_pkg::WPROD_W-1:0]  w_prod;
  logic [ppwd_pkg::DPEND_W+16-1:0] p_lo;
  logic [ppwd_pkg::DPEND_W+17-1:0] p_hi;
  logic [PROD_W-1:0]             prod;
  logic [ppwd_pkg::TERM_W-1:0]   term;
  logic                          add_pendant;

  assign t_dp = tbl_ok ? tbl_q : '0;
  assign s_pp = ppwd_pkg::DMIN_W'(a_q.prox) + ppwd_pkg::DMIN_W'(t_pp)
              + ppwd_pkg::DMIN_W'(b_reg.prox);
  assign s_pd = ppwd_pkg::DMIN_W'(a_q.prox) + ppwd_pkg::DMIN_W'(t_pd)
              + ppwd_pkg::DMIN_W'(b_reg.distal);
  assign s_dp = ppwd_pkg::DMIN_W'(a_q.distal) + ppwd_pkg::DMIN_W'(t_dp)
              + ppwd_pkg::DMIN_W'(b_reg.prox);

  always_comb begin
    if (a_q.edge_id == b_reg.edge_id) begin
      s_min = (a_q.prox > b_reg.prox) ? ppwd_pkg::DMIN_W'(a_q.prox - b_reg.prox)
                                      : ppwd_pkg::DMIN_W'(b_reg.prox - a_q.prox);
    end else begin
      s_min = s_pp;
      if (s_pd < s_min) s_min = s_pd;
      if (s_dp < s_min) s_min = s_dp;
    end
  end

  assign w_full = {{ppwd_pkg::WEIGHT_W{1'b0}}, a_q.weight}
                * {{ppwd_pkg::WEIGHT_W{1'b0}}, b_reg.weight};
  assign prod   = {p_hi, 16'b0} + PROD_W'(p_lo);

  always_ff @(posedge clk) begin
    if (cmd.b_load)   b_reg <= in_place;
    if (cmd.cap_pp)   t_pp  <= tbl_ok ? tbl_q : '0;
    if (cmd.cap_pd)   t_pd  <= tbl_ok ? tbl_q : '0;
    if (cmd.calc_min) d_min <= s_min;
    if (cmd.calc_pend) begin
      d_pend <= ppwd_pkg::DPEND_W'(d_min)
              + (add_pendant ? (ppwd_pkg::DPEND_W'(a_q.pend) + ppwd_pkg::DPEND_W'(b_reg.pend))
                             : '0);
      w_prod <= w_full[ppwd_pkg::WPROD_W-1:0];
    end
    if (cmd.calc_mul) begin
      p_lo <= (ppwd_pkg::DPEND_W+16)'(d_pend) * (ppwd_pkg::DPEND_W+16)'(w_prod[15:0]);
      p_hi <= (ppwd_pkg::DPEND_W+17)'(d_pend)
            * (ppwd_pkg::DPEND_W+17)'(w_prod[ppwd_pkg::WPROD_W-1:16]);
    end
    if (cmd.calc_term) term <= prod[PROD_W-1:32];
  end

  // ---- accumulator and control registers
  logic [ppwd_pkg::SUM_W-1:0] running_sum, out_sum;
  logic [ppwd_pkg::SUM_W:0]   sum_ext;
  logic                       overflow_seen, out_ovf;

  assign sum_ext = {1'b0, running_sum} + (ppwd_pkg::SUM_W+1)'(term);

  always_ff @(posedge clk) begin
    if (rst) begin
      add_pendant     <= 1'b0;
      a_count         <= '0;
      new_set_pending <= 1'b1;
      running_sum     <= '0;
      overflow_seen   <= 1'b0;
      idx             <= '0;
      m_tvalid        <= 1'b0;
    end else begin
      if (cfg_we) add_pendant <= cfg_wdata;

      if (cmd.a_store) begin
        new_set_pending <= 1'b0;
        if (new_set_pending) running_sum <= '0;
        a_count       <= room ? (eff_count + 1'b1) : eff_count;
        overflow_seen <= (overflow_seen && !new_set_pending) || !room;
      end

      if (cmd.idx_clr) begin
        idx <= '0;
      end else if (cmd.idx_inc) begin
        idx <= idx + 1'b1;
      end

      if (cmd.acc) begin
        if (sum_ext[ppwd_pkg::SUM_W]) begin
          running_sum   <= '1;
          overflow_seen <= 1'b1;
        end else begin
          running_sum <= sum_ext[ppwd_pkg::SUM_W-1:0];
        end
      end

      if (cmd.emit) begin
        m_tvalid        <= 1'b1;
        running_sum     <= '0;
        overflow_seen   <= 1'b0;
        new_set_pending <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      out_sum <= running_sum;
      out_ovf <= overflow_seen;
    end
  end

  assign m_tdata = out_sum;
  assign m_tuser = out_ovf;

  assign stat.a_empty   = (a_count == '0);
  assign stat.last_pair = ((CW'(idx) + 1'b1) == a_count);
  assign stat.out_busy  = m_tvalid && !m_tready;

endmodule
